// File: design/slce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slce_pkg: shared type, constants and function
// Constants of the soft-label cross-entropy block and the function that
// builds the log2 mantissa table at elaboration time.
// ----------------------------------------------------------------------------
package slce_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_MODE        = 2'd0;
	localparam logic [1:0] REG_MIN_PROB    = 2'd1;
	localparam logic [1:0] REG_BATCH_COUNT = 2'd2;
	localparam logic [1:0] REG_GRAD_SCALE  = 2'd3;

	// Operand and result widths of the serial units.
	localparam int unsigned MUL_A_W = 64;
	localparam int unsigned MUL_B_W = 32;
	localparam int unsigned DIV_N_W = 64;
	localparam int unsigned DIV_D_W = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);

	// ln(2) in Q.24.
	localparam logic [31:0] LN2_Q24 = 32'd11629080;

	// Largest positive result and the magnitude of the most negative one.
	localparam logic [63:0] RES_MAX     = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] RES_NEG_MAX = 64'h0000_8000_0000_0000;

	typedef logic [24:0] log_entry_t;

	// log2(1 + idx / 2^tbits) in Q.24, found by repeated squaring with 26
	// fraction bits and rounded half up to 24.
	function automatic log_entry_t log2_frac(input int unsigned idx, input int unsigned tbits);
		logic [63:0] x;
		logic [26:0] r;
		x = (64'd1 << tbits) + 64'(idx);
		x = x << (30 - tbits);
		r = '0;
		for (int k = 0; k < 26; k++) begin
			x = (x * x) >> 30;
			r = {r[25:0], 1'b0};
			if (x >= 64'h8000_0000) begin
				r[0] = 1'b1;
				x = x >> 1;
			end
		end
		return log_entry_t'((r + 27'd2) >> 2);
	endfunction

endpackage

// File: design/slce_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slce_mul: bit-serial unsigned multiplier
// Consumes the multiplier one bit per cycle, least significant first, and
// stops as soon as no set bit remains.
// ----------------------------------------------------------------------------
module slce_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [slce_pkg::MUL_A_W-1:0]     a,
	input  logic [slce_pkg::MUL_B_W-1:0]     b,
	output logic                             busy,
	output logic [slce_pkg::MUL_A_W-1:0]     prod
);

	logic                         busy_q;
	logic [slce_pkg::MUL_A_W-1:0] a_q;
	logic [slce_pkg::MUL_B_W-1:0] b_q;
	logic [slce_pkg::MUL_A_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[slce_pkg::MUL_A_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[slce_pkg::MUL_B_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

// File: design/slce_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slce_div: bit-serial restoring divider
// Produces one quotient bit per cycle, most significant first; the quotient
// bits enter the dividend register as its bits leave.
// ----------------------------------------------------------------------------
module slce_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [slce_pkg::DIV_N_W-1:0]     dividend,
	input  logic [slce_pkg::DIV_D_W-1:0]     divisor,
	output logic                             busy,
	output logic [slce_pkg::DIV_N_W-1:0]     quotient
);

	logic                           busy_q;
	logic [slce_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [slce_pkg::DIV_N_W-1:0]   dq_q;
	logic [slce_pkg::DIV_D_W-1:0]   dsr_q;
	logic [slce_pkg::DIV_D_W-1:0]   rem_q;
	logic [slce_pkg::DIV_D_W:0]     trial;
	logic [slce_pkg::DIV_D_W:0]     diff;
	logic                           qbit;

	assign trial = {rem_q, dq_q[slce_pkg::DIV_N_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign qbit  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= slce_pkg::DIV_CNT_W'(slce_pkg::DIV_N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == slce_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[slce_pkg::DIV_D_W-1:0] : trial[slce_pkg::DIV_D_W-1:0];
			dq_q  <= {dq_q[slce_pkg::DIV_N_W-2:0], qbit};
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

// File: design/soft_label_cross_entropy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_label_cross_entropy: soft-label cross-entropy loss and gradient
// Fixed-point loss accumulation with a batch mean, or per-item gradient.
// ----------------------------------------------------------------------------
// Usage. Input requests (prob, soft_label, last_in_batch) are taken on
// in_valid while in_stall is low; results (result_value, is_loss) leave on
// out_valid and are taken while out_stall is low. Registers are written
// through cfg_we, cfg_index and cfg_data; the user writes them only while
// the block is idle, and the block itself does not enforce this. One
// request is processed at a time; in_stall is high from acceptance until
// the request's work is done and, for a request that yields a result,
// its result sits in the output register. A forward request that is not
// last runs a serial multiply by ln(2) and then one by the label; the last
// request of a batch adds the serial division of the sum by the batch count.
// A gradient request runs a serial multiply and a serial divide by the
// probability. The divider is the longest step wherever it is used.
// Reset clears the registers to mode forward, floor 1, batch count 1,
// scale 0, and empties the accumulator and the output register.
// While the receiver stalls, a result waits in the output register; further
// requests are taken, and the next result waits until the register frees.
// ----------------------------------------------------------------------------
module soft_label_cross_entropy #(
	parameter int unsigned LOG_TABLE_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        prob,
	input  logic [15:0]        soft_label,
	input  logic               last_in_batch,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] result_value,
	output logic               is_loss
);

	localparam int unsigned TBL_N = 2 ** LOG_TABLE_BITS;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_LOOK    = 12'b0000_0000_0010,
		S_LN_GO   = 12'b0000_0000_0100,
		S_LN_WAIT = 12'b0000_0000_1000,
		S_TM_GO   = 12'b0000_0001_0000,
		S_TM_WAIT = 12'b0000_0010_0000,
		S_ACC     = 12'b0000_0100_0000,
		S_GR_GO   = 12'b0000_1000_0000,
		S_GR_WAIT = 12'b0001_0000_0000,
		S_DIV_GO  = 12'b0010_0000_0000,
		S_DIV_WAIT= 12'b0100_0000_0000,
		S_OUT     = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic        mode_q;
	logic [15:0] min_prob_q;
	logic [15:0] batch_count_q;
	logic [31:0] grad_scale_q;

	// Request registers.
	logic [15:0] p_q;
	logic [15:0] label_q;
	logic        last_q;
	logic        fwd_q;
	logic [3:0]  z_q;
	slce_pkg::log_entry_t tbl_q;
	logic [63:0] loss_sum_q;

	logic        out_valid_q;
	logic [47:0] res_q;
	logic        is_loss_q;

	slce_pkg::log_entry_t log_tbl [TBL_N];

	for (genvar i = 0; i < TBL_N; i++) begin : g_tbl
		assign log_tbl[i] = slce_pkg::log2_frac(i, LOG_TABLE_BITS);
	end

	logic        accept;
	logic [15:0] floor_p;
	logic [15:0] p_in;
	logic [3:0]  lz;
	logic        lz_found;
	logic [15:0] m_norm;
	logic [LOG_TABLE_BITS-1:0] idx;

	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign floor_p = (min_prob_q == '0) ? 16'd1 : min_prob_q;
	assign p_in    = (prob > floor_p) ? prob : floor_p;

	always_comb begin
		lz = '0;
		lz_found = 1'b0;
		for (int i = 15; i >= 0; i--) begin
			if (!lz_found && p_q[i]) begin
				lz = 4'(15 - i);
				lz_found = 1'b1;
			end
		end
	end

	assign m_norm = p_q << lz;
	assign idx    = m_norm[14 -: LOG_TABLE_BITS];

	// Serial units and their operands.
	logic                          mul_start;
	logic [slce_pkg::MUL_A_W-1:0]  mul_a;
	logic [slce_pkg::MUL_B_W-1:0]  mul_b;
	logic                          mul_busy;
	logic [slce_pkg::MUL_A_W-1:0]  mul_prod;
	logic                          div_start;
	logic [slce_pkg::DIV_N_W-1:0]  div_n;
	logic [slce_pkg::DIV_D_W-1:0]  div_d;
	logic                          div_busy;
	logic [slce_pkg::DIV_N_W-1:0]  div_q;

	logic [28:0] neg_log2;
	logic [52:0] nl_sum;
	logic [44:0] term_sum;
	logic [28:0] term;
	logic [64:0] acc_sum;
	logic [31:0] scale_mag;
	logic [15:0] bc;

	assign neg_log2  = {5'(z_q) + 5'd1, 24'd0} - 29'(tbl_q);
	assign nl_sum    = mul_prod[52:0] + 53'(1 << 23);
	assign term_sum  = mul_prod[44:0] + 45'(1 << 15);
	assign term      = term_sum[44:16];
	assign acc_sum   = {1'b0, loss_sum_q} + 65'(term);
	assign scale_mag = grad_scale_q[31] ? (~grad_scale_q + 32'd1) : grad_scale_q;
	assign bc        = (batch_count_q == '0) ? 16'd1 : batch_count_q;

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_LN_GO: begin
				mul_start = 1'b1;
				mul_a     = 64'(neg_log2);
				mul_b     = slce_pkg::LN2_Q24;
			end
			S_TM_GO: begin
				// -ln(p) in Q.24, rounded.
				mul_start = 1'b1;
				mul_a     = 64'(nl_sum[52:24]);
				mul_b     = 32'(label_q);
			end
			S_GR_GO: begin
				mul_start = 1'b1;
				mul_a     = 64'(scale_mag);
				mul_b     = 32'(label_q);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == S_DIV_GO);
	assign div_n     = fwd_q ? loss_sum_q : {mul_prod[55:0], 8'd0};
	assign div_d     = fwd_q ? bc : p_q;

	slce_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	slce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// Saturation of the quotient into the 48-bit result.
	logic [47:0] res_next;
	logic [63:0] q_clip;

	always_comb begin
		if (fwd_q) begin
			q_clip   = (div_q > slce_pkg::RES_MAX) ? slce_pkg::RES_MAX : div_q;
			res_next = q_clip[47:0];
		end else if (grad_scale_q[31]) begin
			q_clip   = (div_q > slce_pkg::RES_NEG_MAX) ? slce_pkg::RES_NEG_MAX : div_q;
			res_next = 48'd0 - q_clip[47:0];
		end else begin
			q_clip   = (div_q > slce_pkg::RES_MAX) ? slce_pkg::RES_MAX : div_q;
			res_next = q_clip[47:0];
		end
	end

	logic load_out;
	assign load_out = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			min_prob_q    <= 16'd1;
			batch_count_q <= 16'd1;
			grad_scale_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slce_pkg::REG_MODE:        mode_q        <= cfg_data[0];
				slce_pkg::REG_MIN_PROB:    min_prob_q    <= cfg_data[15:0];
				slce_pkg::REG_BATCH_COUNT: batch_count_q <= cfg_data[15:0];
				slce_pkg::REG_GRAD_SCALE:  grad_scale_q  <= cfg_data;
				default:                   mode_q        <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			loss_sum_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= mode_q ? S_GR_GO : S_LOOK;
					end
				end
				S_LOOK:    state_q <= S_LN_GO;
				S_LN_GO:   state_q <= S_LN_WAIT;
				S_LN_WAIT: if (!mul_busy) state_q <= S_TM_GO;
				S_TM_GO:   state_q <= S_TM_WAIT;
				S_TM_WAIT: if (!mul_busy) state_q <= S_ACC;
				S_ACC: begin
					// The accumulator sticks at all ones on overflow.
					loss_sum_q <= acc_sum[64] ? '1 : acc_sum[63:0];
					state_q    <= last_q ? S_DIV_GO : S_IDLE;
				end
				S_GR_GO:   state_q <= S_GR_WAIT;
				S_GR_WAIT: if (!mul_busy) state_q <= S_DIV_GO;
				S_DIV_GO: begin
					if (fwd_q) begin
						loss_sum_q <= '0;
					end
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: if (!div_busy) state_q <= S_OUT;
				S_OUT:     if (load_out) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q     <= p_in;
			label_q <= soft_label;
			last_q  <= last_in_batch;
			fwd_q   <= !mode_q;
		end
		if (state_q == S_LOOK) begin
			z_q   <= lz;
			tbl_q <= log_tbl[idx];
		end
		if (load_out) begin
			res_q     <= res_next;
			is_loss_q <= fwd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = $signed(res_q);
	assign is_loss      = is_loss_q;

endmodule
